FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the parser RTL
// Clocked property checks, switched off while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a consequent follows an antecedent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ip6p_pkg.sv
// ---------------------------------------------------------------------------
// ip6p_pkg
// Types and constants shared by the IPv6 text address parser.
// ---------------------------------------------------------------------------
`default_nettype none

package ip6p_pkg;

  // Address layout
  localparam int GROUP_COUNT = 8;
  localparam int GROUP_W     = 16;
  localparam int HALF_W      = 64;
  localparam int ADDR_W      = GROUP_COUNT * GROUP_W;
  localparam int GCNT_W      = $clog2(GROUP_COUNT + 1);
  localparam int GIDX_W      = $clog2(GROUP_COUNT);

  localparam logic [GCNT_W-1:0] GROUP_COUNT_C = GCNT_W'(GROUP_COUNT);
  localparam logic [2:0]        DIGITS_MAX    = 3'd4;

  // Character codes
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  typedef enum logic [1:0] {
    KIND_HEX,
    KIND_COLON,
    KIND_BAD
  } char_kind_t;

  // Classified character as it waits in the queue
  typedef struct packed {
    char_kind_t kind;
    logic [3:0] nibble;
    logic       last;
  } char_item_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/ip6p_classify.sv
// ---------------------------------------------------------------------------
// ip6p_classify
// Sorts each incoming character into hex digit, colon or bad character and
// decodes the digit value.
// ---------------------------------------------------------------------------
`default_nettype none

module ip6p_classify
  import ip6p_pkg::*;
(
  input  wire logic [7:0] char_code,
  input  wire logic       last_char,
  output char_item_t      item
);

  // Decode the character class and nibble value
  always_comb begin
    item.last   = last_char;
    item.nibble = 4'h0;
    item.kind   = KIND_BAD;
    if (char_code == CHAR_COLON) begin
      item.kind = KIND_COLON;
    end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      item.kind   = KIND_HEX;
      item.nibble = 4'(char_code - CHAR_ZERO);
    end else if (char_code >= CHAR_LA && char_code <= CHAR_LF) begin
      item.kind   = KIND_HEX;
      item.nibble = 4'(char_code - CHAR_LA + 8'd10);
    end else if (char_code >= CHAR_UA && char_code <= CHAR_UF) begin
      item.kind   = KIND_HEX;
      item.nibble = 4'(char_code - CHAR_UA + 8'd10);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ip6p_queue.sv
// ---------------------------------------------------------------------------
// ip6p_queue
// Short queue of classified characters between the front and the parser.
// ---------------------------------------------------------------------------
`default_nettype none

module ip6p_queue
  import ip6p_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire char_item_t push_item,
  input  wire logic    pop,
  output char_item_t   head_item,
  output queue_status_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  char_item_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = entries[rd_ptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ip6p_parse.sv
// ---------------------------------------------------------------------------
// ip6p_parse
// Runs the group/colon state on each queued character, closes the address
// on the last one, then fills the double-colon gap and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module ip6p_parse
  import ip6p_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire char_item_t        q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [HALF_W-1:0]      addr_high,
  output logic [HALF_W-1:0]      addr_low,
  output logic                   status
);

  // Running parse state
  logic [0:GROUP_COUNT-1][GROUP_W-1:0] store;
  logic [GROUP_W-1:0] accum;
  logic [2:0]         digit_count;
  logic [GCNT_W-1:0]  groups_done;
  logic [GCNT_W-1:0]  gap_position;
  logic               gap_seen;
  logic               prev_was_colon;
  logic               error_seen;

  // Next values after one character
  logic [0:GROUP_COUNT-1][GROUP_W-1:0] store_next;
  logic [GROUP_W-1:0] accum_next;
  logic [2:0]         digit_count_next;
  logic [GCNT_W-1:0]  groups_done_next;
  logic [GCNT_W-1:0]  gap_position_next;
  logic               gap_seen_next;
  logic               prev_was_colon_next;
  logic               error_seen_next;

  // Closing of the address on the last character
  logic [0:GROUP_COUNT-1][GROUP_W-1:0] fin_store;
  logic [GCNT_W-1:0]  fin_groups;
  logic               fin_error;

  // Closed address waiting for gap fill
  logic [ADDR_W-1:0]  frame_groups;
  logic [GCNT_W-1:0]  frame_groups_done;
  logic [GCNT_W-1:0]  frame_gap_position;
  logic               frame_gap_seen;
  logic               frame_error;
  logic               frame_valid;
  logic               frame_adv;
  logic               frame_free;

  // Gap fill
  logic [GCNT_W-1:0]  gap_start;
  logic [GCNT_W-1:0]  zero_groups;
  logic [ADDR_W-1:0]  head_mask;
  logic [ADDR_W-1:0]  tail_groups;
  logic [ADDR_W-1:0]  filled;

  assign frame_adv  = frame_valid && (!out_valid || !out_stall);
  assign frame_free = !frame_valid || frame_adv;
  assign q_pop      = q_valid && (!q_item.last || frame_free);

  // Apply one character to the running state
  always_comb begin
    store_next          = store;
    accum_next          = accum;
    digit_count_next    = digit_count;
    groups_done_next    = groups_done;
    gap_position_next   = gap_position;
    gap_seen_next       = gap_seen;
    prev_was_colon_next = prev_was_colon;
    error_seen_next     = error_seen;
    if (!error_seen) begin
      unique case (q_item.kind)
        KIND_COLON: begin
          if (prev_was_colon) begin
            if (gap_seen) begin
              error_seen_next = 1'b1;
            end else begin
              gap_seen_next     = 1'b1;
              gap_position_next = groups_done;
            end
          end else if (digit_count != 3'd0) begin
            if (groups_done >= GROUP_COUNT_C) begin
              error_seen_next = 1'b1;
            end else begin
              store_next[groups_done[GIDX_W-1:0]] = accum;
              groups_done_next = groups_done + 1'b1;
              accum_next       = '0;
              digit_count_next = 3'd0;
            end
          end
          prev_was_colon_next = 1'b1;
        end
        KIND_HEX: begin
          // a lone colon at the start of the text is malformed
          if (prev_was_colon && groups_done == '0 && !gap_seen) begin
            error_seen_next = 1'b1;
          end else if (digit_count >= DIGITS_MAX) begin
            error_seen_next = 1'b1;
          end else begin
            accum_next          = {accum[GROUP_W-5:0], q_item.nibble};
            digit_count_next    = digit_count + 1'b1;
            prev_was_colon_next = 1'b0;
          end
        end
        default: begin
          error_seen_next = 1'b1;
        end
      endcase
    end
  end

  // Close the address: push the final group and check the group count
  always_comb begin
    fin_store  = store_next;
    fin_groups = groups_done_next;
    fin_error  = error_seen_next;
    if (!fin_error) begin
      if (prev_was_colon_next) begin
        // a trailing colon is only allowed as the end of the gap
        if (!(gap_seen_next && gap_position_next == groups_done_next)) begin
          fin_error = 1'b1;
        end
      end else if (groups_done_next >= GROUP_COUNT_C) begin
        fin_error = 1'b1;
      end else begin
        fin_store[groups_done_next[GIDX_W-1:0]] = accum_next;
        fin_groups = groups_done_next + 1'b1;
      end
      if (!fin_error) begin
        if (gap_seen_next) begin
          if (fin_groups >= GROUP_COUNT_C) begin
            fin_error = 1'b1;
          end
        end else if (fin_groups != GROUP_COUNT_C) begin
          fin_error = 1'b1;
        end
      end
    end
  end

  // Hold the parse state, reset it after each address
  always_ff @(posedge clk) begin
    if (rst) begin
      store          <= '0;
      accum          <= '0;
      digit_count    <= '0;
      groups_done    <= '0;
      gap_position   <= '0;
      gap_seen       <= 1'b0;
      prev_was_colon <= 1'b0;
      error_seen     <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        store          <= '0;
        accum          <= '0;
        digit_count    <= '0;
        groups_done    <= '0;
        gap_position   <= '0;
        gap_seen       <= 1'b0;
        prev_was_colon <= 1'b0;
        error_seen     <= 1'b0;
      end else begin
        store          <= store_next;
        accum          <= accum_next;
        digit_count    <= digit_count_next;
        groups_done    <= groups_done_next;
        gap_position   <= gap_position_next;
        gap_seen       <= gap_seen_next;
        prev_was_colon <= prev_was_colon_next;
        error_seen     <= error_seen_next;
      end
    end
  end

  // Load the closed address into the frame stage
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      frame_valid <= 1'b1;
    end else if (frame_adv) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      frame_groups       <= fin_store;
      frame_groups_done  <= fin_groups;
      frame_gap_position <= gap_position_next;
      frame_gap_seen     <= gap_seen_next;
      frame_error        <= fin_error;
    end
  end

  // Fill the gap: keep groups before it, shift the rest to the end
  always_comb begin
    gap_start   = frame_gap_seen ? frame_gap_position : frame_groups_done;
    zero_groups = GROUP_COUNT_C - frame_groups_done;
    for (int i = 0; i < GROUP_COUNT; i++) begin
      head_mask[ADDR_W-1-GROUP_W*i -: GROUP_W] =
        (GCNT_W'(i) < gap_start) ? {GROUP_W{1'b1}} : {GROUP_W{1'b0}};
    end
    tail_groups = (frame_groups & ~head_mask) >> {zero_groups, 4'b0000};
    filled      = (frame_groups & head_mask) | tail_groups;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_adv) begin
      addr_high <= frame_error ? '0 : filled[ADDR_W-1:HALF_W];
      addr_low  <= frame_error ? '0 : filled[HALF_W-1:0];
      status    <= frame_error;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv6_text_address_parser.sv
// ---------------------------------------------------------------------------
// ipv6_text_address_parser
// Parses IPv6 text, one character per word, into a 128-bit address.
// ---------------------------------------------------------------------------
//
//   channel  signals                               handshake
//   -------  ------------------------------------  ------------------------
//   input    char_code, last_char                  in_valid / in_stall
//   output   addr_high, addr_low, status           out_valid / out_stall
//
// One character is taken per cycle while in_stall is low; throughput is set
// by the parser stage, which updates the group state for each character.
// A result passes from the queue through the frame stage to the output
// register after its last character is taken, and waits while out_stall is high.
// in_stall rises only when the classified-character queue is full.
// Synchronous reset clears the queue, parse state and output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv6_text_address_parser
  import ip6p_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        char_code,
  input  wire logic              last_char,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [HALF_W-1:0]      addr_high,
  output logic [HALF_W-1:0]      addr_low,
  output logic                   status
);

`include "assert_macros.svh"

  char_item_t    in_item;
  char_item_t    q_item;
  queue_status_t q_stat;
  logic          q_valid;
  logic          q_pop;

  assign in_stall = q_stat.full;
  assign q_valid  = !q_stat.empty;

  // Classify each character on entry
  ip6p_classify u_classify (
    .char_code (char_code),
    .last_char (last_char),
    .item      (in_item)
  );

  // Buffer classified words
  ip6p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (in_item),
    .pop       (q_pop),
    .head_item (q_item),
    .stat      (q_stat)
  );

  // Parse and emit
  ip6p_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .status    (status)
  );

  // A malformed result carries an all-zero address
  `ASSERT_CLK(a_bad_zero, (out_valid && status) |-> (addr_high == '0 && addr_low == '0), "malformed result with non-zero address")

  // A word taken into an empty queue is visible to the parser next cycle
  `ASSERT_NEXT(a_push_seen, (in_valid && !in_stall && !q_valid), q_valid, "accepted word lost by the queue")

  // An empty queue never stalls the input
  `ASSERT_CLK(a_empty_open, !q_valid |-> !in_stall, "input stalled with an empty queue")

endmodule

`default_nettype wire
